### rtl/daily_alarm_and_oneshot_timer_top_macros.svh
// Assertion macros shared by the checker of the daily alarm and one-shot timer.
`ifndef DAILY_ALARM_AND_ONESHOT_TIMER_TOP_MACROS_SVH
`define DAILY_ALARM_AND_ONESHOT_TIMER_TOP_MACROS_SVH

// Overlapping implication, sampled on clk_i, off during reset.
`define DAOT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define DAOT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/daot_pkg.sv
// Shared constants and types of the daily alarm and one-shot timer.
package daot_pkg;

  // Request codes
  localparam logic [1:0] REQ_POLL   = 2'd0;
  localparam logic [1:0] REQ_ARM    = 2'd1;
  localparam logic [1:0] REQ_CANCEL = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_TZ       = 2'd0;
  localparam logic [1:0] CFG_ALARM_ON = 2'd1;
  localparam logic [1:0] CFG_HOUR     = 2'd2;
  localparam logic [1:0] CFG_MINUTE   = 2'd3;

  // Time constants
  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN  = 17'd60;
  localparam logic [4:0]  HOUR_MAX     = 5'd23;
  localparam logic [5:0]  MINUTE_MAX   = 6'd59;

  // Offset clamp, in minutes
  localparam logic signed [10:0] TZ_LOW  = -11'sd720;
  localparam logic signed [10:0] TZ_HIGH = 11'sd840;

  // 86400 = 128 * 675; the odd part is divided by a truncated reciprocal
  localparam logic [9:0]  DAY_ODD     = 10'd675;
  localparam logic [23:0] DAY_RECIP   = 24'd12725829; // floor(2^33 / 675)
  localparam int          RECIP_SHIFT = 33;

  // Day value that no poll can produce
  localparam logic signed [23:0] LAST_DAY_RESET = 24'sh800000;

  // Request data that rides along the day split
  typedef struct packed {
    logic [1:0]  req;
    logic        poll;   // poll with a positive time
    logic [38:0] now;
    logic [38:0] due;    // already clamped at zero
  } side_t;

  // Into the day split: shifted local time, split into odd part and low bits
  typedef struct packed {
    side_t       side;
    logic [32:0] x;
    logic [6:0]  low7;
  } split_in_t;

  // Out of the day split: local day and second of the day
  typedef struct packed {
    side_t              side;
    logic signed [23:0] day;
    logic [16:0]        rem;
  } split_out_t;

endpackage

### rtl/daot_day_split.sv
// Three-stage pipeline that splits a shifted local time into day and second of day.
module daot_day_split import daot_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  split_in_t  in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output split_out_t out_o
);

  logic        v1_q, v2_q, v3_q;
  logic        rdy1, rdy2, rdy3;
  split_in_t   s1_q;
  side_t       side2_q;
  logic [32:0] x2_q;
  logic [6:0]  low2_q;
  logic [23:0] qe2_q;
  split_out_t  s3_q;

  logic [56:0] prod;
  logic [32:0] qx;
  logic [32:0] diff;
  logic [10:0] r0;
  logic [9:0]  r;
  logic [23:0] q;
  split_out_t  s3_d;

  // Per-stage ready: a stage moves when empty or when the next one moves
  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Reciprocal estimate of x / 675, low by at most one
  assign prod = 57'(s1_q.x) * 57'(DAY_RECIP);

  // Correction: one compare and subtract on the remainder
  always_comb begin
    qx   = 33'(qe2_q) * 33'(DAY_ODD);
    diff = x2_q - qx;
    r0   = diff[10:0];
    if (r0 >= 11'(DAY_ODD)) begin
      q = qe2_q + 24'd1;
      r = 10'(r0 - 11'(DAY_ODD));
    end else begin
      q = qe2_q;
      r = r0[9:0];
    end
    // One day was added ahead of the split to keep the value positive
    s3_d.side = side2_q;
    s3_d.day  = $signed(q - 24'd1);
    s3_d.rem  = {r, low2_q};
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage data
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= in_i;
    if (rdy2 && v1_q) begin
      side2_q <= s1_q.side;
      x2_q    <= s1_q.x;
      low2_q  <= s1_q.low7;
      qe2_q   <= prod[RECIP_SHIFT +: 24];
    end
    if (rdy3 && v2_q) s3_q <= s3_d;
  end

  assign out_valid_o = v3_q;
  assign out_o       = s3_q;

endmodule

### rtl/daily_alarm_and_oneshot_timer_top.sv
// Top level of the daily alarm and one-shot timer.
// One request word is taken per cycle while in_stall_o is low and gives exactly one
// result word, which passes through an input register, a stage holding the
// 33 by 24 bit reciprocal multiply that divides the local time by the day length,
// a correction stage, and the output register, where the timer due time and the
// last alarm day are read and updated in request order. Polls with a time of zero
// or less, arm and cancel requests, and the unused request code all return a word
// with both flags low. The offset register is used saturated to -720..840 minutes;
// an alarm hour above 23 or minute above 59 never matches. Configuration must be
// written only while no request is in flight; the block itself does not enforce this.
module daily_alarm_and_oneshot_timer_top import daot_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [39:0] now_seconds_i,
  input  logic [39:0] due_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        timer_fired_o,
  output logic        alarm_fired_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_wdata_i
);

  logic signed [10:0] tz_q;
  logic               alarm_on_q;
  logic [4:0]         hour_q;
  logic [5:0]         minute_q;

  logic [38:0]        timer_due_q, timer_due_d;
  logic signed [23:0] last_day_q, last_day_d;
  logic               out_valid_q;
  logic               timer_fired_q, timer_fired_d;
  logic               alarm_fired_q, alarm_fired_d;

  logic signed [10:0] tz_c;
  logic [16:0]        tz_ext;
  logic [16:0]        tz60;
  logic [40:0]        local_u;
  split_in_t          split_in;
  logic               split_ready;
  logic               fin_valid;
  logic               fin_ready;
  split_out_t         fin;
  logic [16:0]        target;
  logic               set_ok;
  logic               in_window;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tz_q       <= '0;
      alarm_on_q <= 1'b0;
      hour_q     <= '0;
      minute_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TZ:       tz_q       <= $signed(cfg_wdata_i);
        CFG_ALARM_ON: alarm_on_q <= cfg_wdata_i[0];
        CFG_HOUR:     hour_q     <= cfg_wdata_i[4:0];
        CFG_MINUTE:   minute_q   <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // Saturated offset in seconds, then local time plus one day so it stays positive
  always_comb begin
    if (tz_q < TZ_LOW) begin
      tz_c = TZ_LOW;
    end else if (tz_q > TZ_HIGH) begin
      tz_c = TZ_HIGH;
    end else begin
      tz_c = tz_q;
    end
    tz_ext  = {{6{tz_c[10]}}, tz_c};
    tz60    = (tz_ext << 6) - (tz_ext << 2);
    local_u = {now_seconds_i[39], now_seconds_i} + {{24{tz60[16]}}, tz60}
            + 41'(SEC_PER_DAY);

    split_in.side.req  = req_type_i;
    split_in.side.poll = !now_seconds_i[39] && (|now_seconds_i[38:0]);
    split_in.side.now  = now_seconds_i[38:0];
    split_in.side.due  = due_seconds_i[39] ? 39'd0 : due_seconds_i[38:0];
    split_in.x         = local_u[39:7];
    split_in.low7      = local_u[6:0];
  end

  assign in_stall_o = !split_ready;

  daot_day_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (split_ready),
    .in_i        (split_in),
    .out_valid_o (fin_valid),
    .out_ready_i (fin_ready),
    .out_o       (fin)
  );

  assign fin_ready = !out_valid_q || !out_stall_i;

  // Alarm window: the sixty seconds that start at the set hour and minute
  assign set_ok    = (hour_q <= HOUR_MAX) && (minute_q <= MINUTE_MAX);
  assign target    = 17'(hour_q) * SEC_PER_HOUR + 17'(minute_q) * SEC_PER_MIN;
  assign in_window = (fin.rem >= target) && (fin.rem < target + SEC_PER_MIN);

  // Timer and alarm state, updated in request order
  always_comb begin
    timer_due_d   = timer_due_q;
    last_day_d    = last_day_q;
    timer_fired_d = 1'b0;
    alarm_fired_d = 1'b0;
    case (fin.side.req)
      REQ_ARM:    timer_due_d = fin.side.due;
      REQ_CANCEL: timer_due_d = '0;
      REQ_POLL: begin
        if (fin.side.poll) begin
          if ((timer_due_q != '0) && (fin.side.now >= timer_due_q)) begin
            timer_due_d   = '0;
            timer_fired_d = 1'b1;
          end
          if (alarm_on_q && set_ok && in_window && (fin.day != last_day_q)) begin
            last_day_d    = fin.day;
            alarm_fired_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_due_q   <= '0;
      last_day_q    <= LAST_DAY_RESET;
      out_valid_q   <= 1'b0;
      timer_fired_q <= 1'b0;
      alarm_fired_q <= 1'b0;
    end else if (fin_ready) begin
      out_valid_q <= fin_valid;
      if (fin_valid) begin
        timer_due_q   <= timer_due_d;
        last_day_q    <= last_day_d;
        timer_fired_q <= timer_fired_d;
        alarm_fired_q <= alarm_fired_d;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign timer_fired_o = timer_fired_q;
  assign alarm_fired_o = alarm_fired_q;

endmodule

### rtl/daot_checker.sv
// Port-level checker of the daily alarm and one-shot timer, bound to the top level.
`include "daily_alarm_and_oneshot_timer_top_macros.svh"

module daot_checker import daot_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  req_type_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        timer_fired_o,
  input logic        alarm_fired_o
);

  // A stalled result word holds
  `DAOT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(timer_fired_o) && $stable(alarm_fired_o), "stalled result word changed")

  // Without output stall a word that is taken comes out once it has passed the split stages and the output register
  `DAOT_ASSERT_NEXT(a_latency, (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i, out_valid_o, "result word missing after pipeline latency")

  // Anything but a poll gives a word with both flags low
  `DAOT_ASSERT_NEXT(a_nonpoll_quiet, (in_valid_i && !in_stall_o && (req_type_i != REQ_POLL)) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i, !timer_fired_o && !alarm_fired_o, "flag raised for a non-poll request")

  // Input stalls only behind a stalled result word
  `DAOT_ASSERT_NOW(a_stall_needs_full, in_stall_o, out_valid_o && out_stall_i, "input stalled while the result side can move")

endmodule

bind daily_alarm_and_oneshot_timer_top daot_checker u_daot_checker (.*);
